>>> design/rc_pwm_pulse_width_capture_macros.svh
// Assertion macros used by the checker of the RC PWM pulse width capture block.
// Needs nothing else; included by the checker file by bare name.
`ifndef RC_PWM_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define RC_PWM_PULSE_WIDTH_CAPTURE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RCPW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition in one cycle that must be followed by a consequence in the next.
`define RCPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rcpw_pkg.sv
// Shared types and constants of the RC PWM pulse width capture block.
// Used by the interfaces, all modules and the checker; depends on nothing.
package rcpw_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned PIN_BITS   = 6;
  localparam int unsigned VAL_W      = 15;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned READ_CH_W  = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;

  // Default channel count.
  localparam int unsigned CHANNELS_DEF = 6;

  // Register reset values and the answer for a read of a nonexistent channel.
  localparam logic [VAL_W-1:0] MIN_PULSE_RST = 15'd1000;
  localparam logic [VAL_W-1:0] MAX_PULSE_RST = 15'd2000;
  localparam logic [VAL_W-1:0] INVALID_READ  = 15'd1200;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 1'b1;

  // Operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // What one lane reports to the merge stage.
  typedef struct packed {
    logic             upd;
    logic [VAL_W-1:0] value;
  } lane_t;

  // One result item.
  typedef struct packed {
    logic [VAL_W-1:0]    read_value;
    logic [PIN_BITS-1:0] updated;
  } res_t;

endpackage

>>> design/rcpw_ifs.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on rcpw_pkg for the field widths.
interface rcpw_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [rcpw_pkg::PIN_BITS-1:0]   pins;
  logic [rcpw_pkg::TICK_W-1:0]     timer_ticks;
  logic [rcpw_pkg::READ_CH_W-1:0]  read_channel;

  modport source (output valid, op, pins, timer_ticks, read_channel, input ready);
  modport sink   (input valid, op, pins, timer_ticks, read_channel, output ready);
endinterface

interface rcpw_out_if;
  logic                          valid;
  logic                          ready;
  logic [rcpw_pkg::VAL_W-1:0]    read_value;
  logic [rcpw_pkg::PIN_BITS-1:0] updated;

  modport source (output valid, read_value, updated, input ready);
  modport sink   (input valid, read_value, updated, output ready);
endinterface

>>> design/rcpw_lane.sv
// One channel lane: edge detection, start time capture and width check.
// Depends on rcpw_pkg for widths and the lane report type.
module rcpw_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_i,
  input  logic                          cur_i,
  input  logic                          old_i,
  input  logic [rcpw_pkg::VAL_W-1:0]    now_i,
  input  logic [rcpw_pkg::VAL_W-1:0]    min_i,
  input  logic [rcpw_pkg::VAL_W-1:0]    max_i,
  output rcpw_pkg::lane_t               lane_o
);

  logic [rcpw_pkg::VAL_W-1:0] rise_q, rise_d;
  logic [rcpw_pkg::VAL_W-1:0] value_q, value_d;
  logic [rcpw_pkg::VAL_W:0]   width;
  logic                       rise_edge, fall_edge, in_range;

  // A wrapped measurement sets the top bit and so always exceeds the maximum.
  assign width     = {1'b0, now_i} - {1'b0, rise_q};
  assign rise_edge = sample_i && cur_i && !old_i;
  assign fall_edge = sample_i && !cur_i && old_i;
  assign in_range  = (width >= {1'b0, min_i}) && (width <= {1'b0, max_i});

  // Next state of the start time and the stored width.
  always_comb begin
    rise_d  = rise_q;
    value_d = value_q;
    if (rise_edge) begin
      rise_d = now_i;
    end
    if (fall_edge && in_range) begin
      value_d = width[rcpw_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q  <= '0;
      value_q <= '0;
    end else begin
      rise_q  <= rise_d;
      value_q <= value_d;
    end
  end

  assign lane_o.upd   = fall_edge && in_range;
  assign lane_o.value = value_q;

endmodule

>>> design/rcpw_merge.sv
// Merge stage: gathers lane update bits into a mask and selects a read value.
// Depends on rcpw_pkg for the lane report and result types.
module rcpw_merge #(
  parameter int unsigned Channels = rcpw_pkg::CHANNELS_DEF
) (
  input  logic                             op_i,
  input  logic [rcpw_pkg::READ_CH_W-1:0]   read_channel_i,
  input  rcpw_pkg::lane_t                  lanes_i [Channels],
  output rcpw_pkg::res_t                   res_o
);

  localparam int unsigned ChW = rcpw_pkg::READ_CH_W;

  logic [rcpw_pkg::PIN_BITS-1:0] upd_mask;
  logic [rcpw_pkg::VAL_W-1:0]    sel_value;

  // Only channels that have a pin bit can report an update.
  for (genvar k = 0; k < rcpw_pkg::PIN_BITS; k++) begin : g_mask
    if (k < Channels) begin : g_live
      assign upd_mask[k] = lanes_i[k].upd;
    end else begin : g_none
      assign upd_mask[k] = 1'b0;
    end
  end

  // Read select; an index past the last channel keeps the invalid value.
  always_comb begin
    sel_value = rcpw_pkg::INVALID_READ;
    for (int k = 0; k < Channels; k++) begin
      if (read_channel_i == ChW'(k)) begin
        sel_value = lanes_i[k].value;
      end
    end
  end

  always_comb begin
    if (op_i == rcpw_pkg::OP_READ) begin
      res_o.read_value = sel_value;
      res_o.updated    = '0;
    end else begin
      res_o.read_value = '0;
      res_o.updated    = upd_mask;
    end
  end

endmodule

>>> design/rcpw_out_buf.sv
// Two-entry output buffer: an output register with a skid entry behind it.
// Depends on rcpw_pkg for the result type.
module rcpw_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rcpw_pkg::res_t  data_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            pop_ready_i,
  output rcpw_pkg::res_t  data_o
);

  logic           head_v_q, head_v_d, skid_v_q, skid_v_d;
  rcpw_pkg::res_t head_q, head_d, skid_q, skid_d;
  logic           pop;

  assign pop     = head_v_q && pop_ready_i;
  assign ready_o = !skid_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;

  // The skid entry refills the head first so that items leave in order.
  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        skid_v_d = push_i;
        skid_d   = data_i;
      end else begin
        head_v_d = push_i;
        head_d   = data_i;
      end
    end else if (push_i) begin
      if (!head_v_q) begin
        head_v_d = 1'b1;
        head_d   = data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

>>> design/rc_pwm_pulse_width_capture.sv
// A result is valid in the cycle after its item is accepted when the output is empty.
// Throughput: one item per cycle while input ready is high; each channel lane does one
// subtract and two compares. A two-entry output buffer lets two results wait before
// input ready drops. Reset clears pin history, start times and widths, and loads
// 1000/2000 into the pulse limits; the block accepts items in the first cycle after reset.
module rc_pwm_pulse_width_capture #(
  parameter int unsigned Channels = rcpw_pkg::CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rcpw_in_if.sink                           in_ch,
  rcpw_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rcpw_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [rcpw_pkg::VAL_W-1:0]    min_q, max_q;
  logic [rcpw_pkg::PIN_BITS-1:0] prev_q;
  logic                          in_fire, sample_fire, buf_ready;
  logic [rcpw_pkg::VAL_W-1:0]    now;
  rcpw_pkg::lane_t               lanes [Channels];
  rcpw_pkg::res_t                res, res_out;

  assign in_ch.ready = buf_ready;
  assign in_fire     = in_ch.valid && buf_ready;
  assign sample_fire = in_fire && (in_ch.op == rcpw_pkg::OP_SAMPLE);
  assign now         = in_ch.timer_ticks[rcpw_pkg::TICK_W-1:1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= rcpw_pkg::MIN_PULSE_RST;
      max_q <= rcpw_pkg::MAX_PULSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcpw_pkg::CFG_MIN_PULSE: min_q <= cfg_data_i;
        rcpw_pkg::CFG_MAX_PULSE: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pin levels of the last sample item; reads leave them alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (sample_fire) begin
      prev_q <= in_ch.pins;
    end
  end

  // One lane per channel; channels past the pin field see a steady low level.
  for (genvar k = 0; k < Channels; k++) begin : g_lane
    logic cur, old;
    if (k < rcpw_pkg::PIN_BITS) begin : g_pin
      assign cur = in_ch.pins[k];
      assign old = prev_q[k];
    end else begin : g_nopin
      assign cur = 1'b0;
      assign old = 1'b0;
    end

    rcpw_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sample_i (sample_fire),
      .cur_i    (cur),
      .old_i    (old),
      .now_i    (now),
      .min_i    (min_q),
      .max_i    (max_q),
      .lane_o   (lanes[k])
    );
  end

  rcpw_merge #(
    .Channels (Channels)
  ) u_merge (
    .op_i           (in_ch.op),
    .read_channel_i (in_ch.read_channel),
    .lanes_i        (lanes),
    .res_o          (res)
  );

  rcpw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (out_ch.valid),
    .pop_ready_i (out_ch.ready),
    .data_o      (res_out)
  );

  assign out_ch.read_value = res_out.read_value;
  assign out_ch.updated    = res_out.updated;

endmodule

>>> design/rcpw_checker.sv
// Port-level checker for the RC PWM pulse width capture block, bound to the top level.
// Depends on rcpw_pkg and the assertion macros header.
`include "rc_pwm_pulse_width_capture_macros.svh"

module rcpw_checker #(
  parameter int unsigned Channels = rcpw_pkg::CHANNELS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [rcpw_pkg::VAL_W-1:0]    out_read_value_i,
  input logic [rcpw_pkg::PIN_BITS-1:0] out_updated_i
);

  logic in_fire;
  logic [rcpw_pkg::PIN_BITS-1:0] high_upd;

  assign in_fire  = in_valid_i && in_ready_i;
  assign high_upd = out_updated_i >> Channels;

  // A result waiting at the output stays until it is taken.
  `RCPW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // A result is either a read value or an update mask, never both.
  `RCPW_ASSERT(a_res_kind, clk_i, rst_ni, out_valid_i |-> (out_read_value_i == '0 || out_updated_i == '0), "result carries both read value and update mask")

  // Only existing channels can be reported as updated.
  `RCPW_ASSERT(a_upd_range, clk_i, rst_ni, out_valid_i |-> (high_upd == '0), "update reported for nonexistent channel")

  // An item accepted with an empty output shows its result in the next cycle.
  `RCPW_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_fire && !out_valid_i, out_valid_i, "result missing one cycle after accept")

  // Input back-pressure only happens while results are waiting.
  `RCPW_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_i |-> out_valid_i, "input stalled with empty output")

endmodule

bind rc_pwm_pulse_width_capture rcpw_checker #(
  .Channels (Channels)
) u_rcpw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_ch.valid),
  .in_ready_i       (in_ch.ready),
  .out_valid_i      (out_ch.valid),
  .out_ready_i      (out_ch.ready),
  .out_read_value_i (out_ch.read_value),
  .out_updated_i    (out_ch.updated)
);
